// File: rtl/backslash_escape_codec_macros.svh
// assertion macros for the backslash escape codec
// used by modules that check their own control logic; no other dependencies
`ifndef BACKSLASH_ESCAPE_CODEC_MACROS_SVH
`define BACKSLASH_ESCAPE_CODEC_MACROS_SVH

// same-cycle implication, disabled in reset
`define BEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bec check failed");

// next-cycle implication, disabled in reset
`define BEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bec check failed");

`endif

// File: rtl/bec_pkg.sv
// types and constants shared by the backslash escape codec
// no dependencies
package bec_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LETTER_N  = 8'h6E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_NUL       = 8'h00;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN     = 2'd2;

  localparam logic DIR_ESCAPE   = 1'b0;
  localparam logic DIR_UNESCAPE = 1'b1;

  localparam logic [1:0] MODE_NEWLINE = 2'd0;
  localparam logic [1:0] MODE_QUOTE   = 2'd1;
  localparam logic [1:0] MODE_CAPB    = 2'd2;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } bec_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_terminator;
    logic       truncated;
  } bec_out_t;

  // one classified item: zero, one or two result beats
  typedef struct packed {
    logic [1:0] cnt;
    bec_out_t   first;
    bec_out_t   second;
  } bec_entry_t;

endpackage

// File: rtl/backslash_escape_codec.sv
// backslash escape codec top level: front classifier, entry queue, beat back end
// depends on bec_pkg, bec_front, bec_queue, bec_back
//
// Usage
//   item channel: one string byte per beat (item.in_byte), or an end beat
//   (item.end_of_string) that closes the string. result channel: one output
//   byte per beat; the string closes with a terminator beat carrying the
//   truncation flag. Both channels move a beat when valid is high and stall
//   is low.
//   cfg_write/cfg_index/cfg_data set direction (0), escape mode (1) and
//   max_len (2); write only while no string beats are in flight.
//   A result beat goes through the queue write, then the output register load.
//   Throughput: one item per cycle while the queue has room; the single result
//   port gives one beat per cycle while result_stall is low, so an item that
//   yields an escape pair or a pending backslash plus terminator occupies the
//   result port for two beats. The QUEUE_DEPTH-entry queue absorbs the
//   difference; item_stall rises only when it is full.
//   A stall on the result side holds the output register and fills the
//   queue, then backs up into the item side.
//   Reset (rst, synchronous) empties the queue and the output register,
//   clears the per-string state and returns the configuration to its
//   defaults.
module backslash_escape_codec #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bec_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  bec_pkg::bec_in_t                item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bec_pkg::bec_out_t               result
);

  bec_pkg::bec_entry_t entry;
  bec_pkg::bec_entry_t head;
  logic                accept;
  logic                push;
  logic                full;
  logic                pop;
  logic                q_valid;

  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign push       = accept && (entry.cnt != 2'd0);

  bec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .entry     (entry)
  );

  bec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .nonempty  (q_valid),
    .head      (head)
  );

  bec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/bec_front.sv
// front end: configuration registers, per-string state and item classification
// depends on bec_pkg
module bec_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bec_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bec_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              accept,
  input  bec_pkg::bec_in_t                  item,
  output bec_pkg::bec_entry_t               entry
);

  logic        direction;
  logic [1:0]  escape_mode;
  logic [15:0] max_len;

  logic [15:0] out_count;
  logic [15:0] out_count_next;
  logic        pending;
  logic        pending_next;
  logic        stopped;
  logic        stopped_next;

  logic [15:0] cap;
  logic [16:0] cnt1;
  logic [7:0]  b;
  logic        esc;

  assign cap  = (max_len == 16'd0) ? 16'd0 : max_len - 16'd1;
  assign cnt1 = {1'b0, out_count} + 17'd1;
  assign b    = item.in_byte;
  assign esc  = (b == bec_pkg::CH_NEWLINE) ||
                (escape_mode == bec_pkg::MODE_QUOTE && b == bec_pkg::CH_QUOTE) ||
                (escape_mode == bec_pkg::MODE_CAPB && b == bec_pkg::CH_BACKSLASH);

  always_comb begin
    entry          = '0;
    out_count_next = out_count;
    pending_next   = pending;
    stopped_next   = stopped;
    if (item.end_of_string) begin
      if (direction == bec_pkg::DIR_UNESCAPE && pending) begin
        entry.cnt    = 2'd2;
        entry.first  = '{bec_pkg::CH_BACKSLASH, 1'b0, 1'b0};
        entry.second = '{bec_pkg::CH_NUL, 1'b1, stopped};
      end else begin
        entry.cnt   = 2'd1;
        entry.first = '{bec_pkg::CH_NUL, 1'b1, stopped};
      end
      out_count_next = 16'd0;
      pending_next   = 1'b0;
      stopped_next   = 1'b0;
    end else if (direction == bec_pkg::DIR_ESCAPE) begin
      if (!stopped) begin
        if (out_count >= cap) begin
          stopped_next = 1'b1;
        end else if (esc) begin
          if (cnt1 >= {1'b0, cap}) begin
            stopped_next = 1'b1;
          end else begin
            entry.cnt      = 2'd2;
            entry.first    = '{bec_pkg::CH_BACKSLASH, 1'b0, 1'b0};
            entry.second   = '{(b == bec_pkg::CH_NEWLINE) ? bec_pkg::CH_LETTER_N : b,
                               1'b0, 1'b0};
            out_count_next = out_count + 16'd2;
          end
        end else begin
          entry.cnt      = 2'd1;
          entry.first    = '{b, 1'b0, 1'b0};
          out_count_next = out_count + 16'd1;
        end
      end
    end else if (!pending) begin
      if (!stopped) begin
        if (out_count >= cap) begin
          stopped_next = 1'b1;
        end else if (b == bec_pkg::CH_BACKSLASH) begin
          pending_next = 1'b1;
        end else begin
          entry.cnt      = 2'd1;
          entry.first    = '{b, 1'b0, 1'b0};
          out_count_next = out_count + 16'd1;
        end
      end
    end else begin
      pending_next = 1'b0;
      if (b == bec_pkg::CH_LETTER_N) begin
        entry.cnt      = 2'd1;
        entry.first    = '{bec_pkg::CH_NEWLINE, 1'b0, 1'b0};
        out_count_next = out_count + 16'd1;
      end else if ((escape_mode == bec_pkg::MODE_QUOTE && b == bec_pkg::CH_QUOTE) ||
                   escape_mode == bec_pkg::MODE_CAPB) begin
        entry.cnt      = 2'd1;
        entry.first    = '{b, 1'b0, 1'b0};
        out_count_next = out_count + 16'd1;
      end else begin
        // undecoded pair: backslash out, second byte taken as fresh
        entry.cnt      = 2'd1;
        entry.first    = '{bec_pkg::CH_BACKSLASH, 1'b0, 1'b0};
        out_count_next = out_count + 16'd1;
        if (!stopped) begin
          if (cnt1 >= {1'b0, cap}) begin
            stopped_next = 1'b1;
          end else if (b == bec_pkg::CH_BACKSLASH) begin
            pending_next = 1'b1;
          end else begin
            entry.cnt      = 2'd2;
            entry.second   = '{b, 1'b0, 1'b0};
            out_count_next = out_count + 16'd2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= bec_pkg::DIR_ESCAPE;
      escape_mode <= bec_pkg::MODE_NEWLINE;
      max_len     <= bec_pkg::MAX_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bec_pkg::CFG_DIRECTION:   direction   <= cfg_data[0];
        bec_pkg::CFG_ESCAPE_MODE: escape_mode <= cfg_data[1:0];
        bec_pkg::CFG_MAX_LEN:     max_len     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 16'd0;
      pending   <= 1'b0;
      stopped   <= 1'b0;
    end else if (accept) begin
      out_count <= out_count_next;
      pending   <= pending_next;
      stopped   <= stopped_next;
    end
  end

endmodule

// File: rtl/bec_queue.sv
// short queue of classified entries between front and back
// depends on bec_pkg
module bec_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bec_pkg::bec_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output bec_pkg::bec_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  bec_pkg::bec_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/bec_back.sv
// back end: splits queued entries into result beats behind an output register
// depends on bec_pkg and backslash_escape_codec_macros.svh
`include "backslash_escape_codec_macros.svh"

module bec_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  bec_pkg::bec_entry_t head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output bec_pkg::bec_out_t   result
);

  logic              sel;
  logic              load;
  logic              last;
  bec_pkg::bec_out_t beat;

  assign beat = sel ? head.second : head.first;
  assign last = sel || (head.cnt == 2'd1);
  assign load = q_valid && (!result_valid || !result_stall);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sel          <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        sel          <= !last;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `BEC_ASSERT_NOW(a_entry_nonempty, clk, rst, q_valid, head.cnt != 2'd0)
  `BEC_ASSERT_NOW(a_sel_on_pair, clk, rst, sel, q_valid && head.cnt == 2'd2)
  `BEC_ASSERT_NOW(a_term_zero, clk, rst, result_valid && result.is_terminator,
                  result.out_byte == bec_pkg::CH_NUL)
  `BEC_ASSERT_NOW(a_trunc_on_term, clk, rst, result_valid && result.truncated,
                  result.is_terminator)

endmodule

// File: dv/tb.sv
// testbench for backslash_escape_codec: directed and random strings in both directions
// depends on bec_pkg and the codec rtl; self-checking against an in-bench codec model
module tb;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int ITEM_TARGET  = 1200;
  localparam int SETTLE       = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_CAP    = 100;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [bec_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bec_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            item_valid = 1'b0;
  logic                            item_stall;
  bec_pkg::bec_in_t                item = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  bec_pkg::bec_out_t               result;

  // codec model state and configuration
  logic        cur_dir = bec_pkg::DIR_ESCAPE;
  logic [1:0]  cur_mode = bec_pkg::MODE_NEWLINE;
  logic [15:0] cur_max = bec_pkg::MAX_LEN_RESET;
  logic [15:0] n_out = '0;
  logic        bs_held = 1'b0;
  logic        out_full = 1'b0;

  bec_pkg::bec_in_t  pend_items[$];
  bec_pkg::bec_out_t exp_beats[$];
  int n_queued = 0;
  int n_acc = 0;
  int n_err = 0;
  int tx_style = 0;
  int rx_style = 0;
  int tx_left = 0;
  int rx_left = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet = 0;

  backslash_escape_codec u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report(string msg);
    if (n_err < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    n_err++;
  endtask

  function automatic int draw_wait(int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic int room_limit();
    return (cur_max == 16'd0) ? 0 : int'(cur_max) - 1;
  endfunction

  function automatic void expect_beat(logic [7:0] b, logic term, logic trunc);
    bec_pkg::bec_out_t r;
    r.out_byte = b;
    r.is_terminator = term;
    r.truncated = trunc;
    exp_beats.push_back(r);
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    expect_beat(b, 1'b0, 1'b0);
    n_out = n_out + 16'd1;
  endfunction

  function automatic void escape_one(logic [7:0] b);
    logic esc;
    if (out_full) return;
    if (int'(n_out) >= room_limit()) begin
      out_full = 1'b1;
      return;
    end
    esc = (b == bec_pkg::CH_NEWLINE) ||
          (cur_mode == bec_pkg::MODE_QUOTE && b == bec_pkg::CH_QUOTE) ||
          (cur_mode == bec_pkg::MODE_CAPB && b == bec_pkg::CH_BACKSLASH);
    if (esc) begin
      if (int'(n_out) + 2 > room_limit()) begin
        out_full = 1'b1;
        return;
      end
      emit_byte(bec_pkg::CH_BACKSLASH);
      emit_byte((b == bec_pkg::CH_NEWLINE) ? bec_pkg::CH_LETTER_N : b);
    end else begin
      emit_byte(b);
    end
  endfunction

  function automatic void unescape_fresh(logic [7:0] b);
    if (out_full) return;
    if (int'(n_out) >= room_limit()) begin
      out_full = 1'b1;
      return;
    end
    if (b == bec_pkg::CH_BACKSLASH) bs_held = 1'b1;
    else emit_byte(b);
  endfunction

  function automatic void unescape_one(logic [7:0] b);
    if (!bs_held) begin
      unescape_fresh(b);
      return;
    end
    bs_held = 1'b0;
    if (b == bec_pkg::CH_LETTER_N) emit_byte(bec_pkg::CH_NEWLINE);
    else if (cur_mode == bec_pkg::MODE_QUOTE && b == bec_pkg::CH_QUOTE) emit_byte(b);
    else if (cur_mode == bec_pkg::MODE_CAPB) emit_byte(b);
    else begin
      emit_byte(bec_pkg::CH_BACKSLASH);
      unescape_fresh(b);
    end
  endfunction

  // expected result beats for one accepted item
  function automatic void codec_step(bec_pkg::bec_in_t it);
    if (it.end_of_string) begin
      if (cur_dir == bec_pkg::DIR_UNESCAPE && bs_held) emit_byte(bec_pkg::CH_BACKSLASH);
      expect_beat(bec_pkg::CH_NUL, 1'b1, out_full);
      n_out = '0;
      bs_held = 1'b0;
      out_full = 1'b0;
    end else if (cur_dir == bec_pkg::DIR_ESCAPE) begin
      escape_one(it.in_byte);
    end else begin
      unescape_one(it.in_byte);
    end
  endfunction

  // item driver
  always @(posedge clk) begin : drv
    logic go;
    if (rst) begin
      item_valid <= 1'b0;
      tx_left = 0;
    end else begin
      go = item_valid;
      if (item_valid && !item_stall) begin
        codec_step(item);
        n_acc++;
        go = 1'b0;
      end
      if (!go && pend_items.size() != 0) begin
        if (tx_left > 0) begin
          tx_left--;
        end else begin
          item <= pend_items.pop_front();
          go = 1'b1;
          tx_left = draw_wait(tx_style);
        end
      end
      item_valid <= go;
    end
  end

  // result monitor and stall control
  always @(posedge clk) begin : mon
    logic s;
    bec_pkg::bec_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
      rx_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (exp_beats.size() == 0) begin
          report($sformatf("unexpected beat byte=%h term=%b trunc=%b",
                           result.out_byte, result.is_terminator, result.truncated));
        end else begin
          want = exp_beats.pop_front();
          if (result.out_byte !== want.out_byte)
            report($sformatf("out_byte %h, expected %h", result.out_byte, want.out_byte));
          if (result.is_terminator !== want.is_terminator)
            report($sformatf("is_terminator %b, expected %b",
                             result.is_terminator, want.is_terminator));
          if (result.truncated !== want.truncated)
            report($sformatf("truncated %b, expected %b", result.truncated, want.truncated));
        end
        rx_left = draw_wait(rx_style);
      end
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (hold_done != hold_asks) begin
        hold_done++;
        hold_left = HOLD_CYCLES - 1;
        s = 1'b1;
      end else if (rx_left > 0) begin
        rx_left--;
        s = 1'b1;
      end else begin
        s = 1'b0;
      end
      result_stall <= s;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_item(logic [7:0] b, logic eos);
    bec_pkg::bec_in_t it;
    it.in_byte = b;
    it.end_of_string = eos;
    pend_items.push_back(it);
    n_queued++;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return bec_pkg::CH_NEWLINE;
    if (r < 7) return bec_pkg::CH_QUOTE;
    if (r < 11) return bec_pkg::CH_BACKSLASH;
    if (r < 14) return bec_pkg::CH_LETTER_N;
    return 8'($urandom_range(0, 255));
  endfunction

  // tidy strings are built from plain bytes and complete escape pairs
  task automatic add_string(bit tidy, bit closed);
    int len;
    int k;
    logic [7:0] b;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    k = 0;
    while (k < len) begin
      if (tidy && $urandom_range(0, 2) == 0) begin
        add_item(bec_pkg::CH_BACKSLASH, 1'b0);
        case ($urandom_range(0, 3))
          0: b = bec_pkg::CH_LETTER_N;
          1: b = bec_pkg::CH_QUOTE;
          2: b = bec_pkg::CH_BACKSLASH;
          default: b = 8'($urandom_range(0, 255));
        endcase
        add_item(b, 1'b0);
        k += 2;
      end else begin
        if (tidy) begin
          b = 8'($urandom_range(0, 255));
          if (b == bec_pkg::CH_BACKSLASH) b = bec_pkg::CH_LETTER_N;
        end else begin
          b = pick_byte();
        end
        add_item(b, 1'b0);
        k++;
      end
    end
    if (closed) add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic put_reg(logic [bec_pkg::CFG_INDEX_W-1:0] idx,
                         logic [bec_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      bec_pkg::CFG_DIRECTION:   cur_dir = val[0];
      bec_pkg::CFG_ESCAPE_MODE: cur_mode = val[1:0];
      bec_pkg::CFG_MAX_LEN:     cur_max = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic d, logic [1:0] m, logic [15:0] ml);
    put_reg(bec_pkg::CFG_DIRECTION, {15'd0, d});
    put_reg(bec_pkg::CFG_ESCAPE_MODE, {14'd0, m});
    put_reg(bec_pkg::CFG_MAX_LEN, ml);
    @(posedge clk);
    cfg_write <= 1'b0;
    tx_style = $urandom_range(0, 2);
    rx_style = $urandom_range(0, 2);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_acc != n_queued || exp_beats.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stim
    int phase;
    int r;
    logic d;
    logic [1:0] m;
    logic [15:0] ml;
    bit tidy;
    bit hold_phase;
    int nstr;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: escape, newline only, full length
    tx_style = 2;
    rx_style = 2;
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(bec_pkg::CH_NEWLINE, 1'b0);
    add_item(bec_pkg::CH_QUOTE, 1'b0);
    add_item(bec_pkg::CH_BACKSLASH, 1'b0);
    add_item(bec_pkg::CH_LETTER_N, 1'b0);
    add_item(8'hA5, 1'b1);
    wait_idle();

    // unused mode acts as newline only; trailing backslash
    configure(bec_pkg::DIR_UNESCAPE, MODE_UNUSED, bec_pkg::MAX_LEN_RESET);
    add_item(bec_pkg::CH_BACKSLASH, 1'b0);
    add_item(bec_pkg::CH_LETTER_N, 1'b0);
    add_item(bec_pkg::CH_BACKSLASH, 1'b0);
    add_item(bec_pkg::CH_QUOTE, 1'b0);
    add_item(bec_pkg::CH_BACKSLASH, 1'b0);
    add_item(8'h00, 1'b1);
    wait_idle();

    // capb decode, then running out of room
    configure(bec_pkg::DIR_UNESCAPE, bec_pkg::MODE_CAPB, 16'd3);
    add_item(bec_pkg::CH_BACKSLASH, 1'b0);
    add_item("x", 1'b0);
    add_item("a", 1'b0);
    add_item("b", 1'b0);
    add_item("c", 1'b0);
    add_item(8'hFF, 1'b1);
    wait_idle();

    // escape pair that does not fit is dropped whole
    configure(bec_pkg::DIR_ESCAPE, bec_pkg::MODE_QUOTE, 16'd3);
    add_item("a", 1'b0);
    add_item(bec_pkg::CH_QUOTE, 1'b0);
    add_item(8'h00, 1'b1);
    wait_idle();

    // zero max_len behaves as one
    configure(bec_pkg::DIR_ESCAPE, bec_pkg::MODE_NEWLINE, 16'd0);
    add_item("a", 1'b0);
    add_item(8'h00, 1'b1);
    wait_idle();

    phase = 0;
    while (n_queued < ITEM_TARGET) begin
      hold_phase = (phase == 2 || phase == 11);
      d = $urandom_range(0, 1);
      r = $urandom_range(0, 9);
      m = (r == 9) ? MODE_UNUSED : 2'(r % 3);
      case ($urandom_range(0, 9))
        0: ml = 16'd1;
        1: ml = 16'd2;
        2: ml = 16'd3;
        3: ml = bec_pkg::MAX_LEN_RESET;
        4: ml = 16'($urandom_range(0, 65535));
        default: ml = 16'($urandom_range(4, 24));
      endcase
      // full room so the held strings really fill the block
      if (hold_phase) ml = bec_pkg::MAX_LEN_RESET;
      configure(d, m, ml);
      if (hold_phase) begin
        // long receiver hold while the sender keeps offering
        tx_style = 0;
        hold_asks++;
      end
      nstr = hold_phase ? 6 : $urandom_range(2, 6);
      for (int s = 0; s < nstr; s++) begin
        tidy = (d == bec_pkg::DIR_UNESCAPE) && ($urandom_range(0, 4) != 0);
        add_string(tidy, (s != nstr - 1) || ($urandom_range(0, 9) != 0));
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: backslash_escape_codec.f
+incdir+rtl
rtl/bec_pkg.sv
rtl/bec_front.sv
rtl/bec_queue.sv
rtl/bec_back.sv
rtl/backslash_escape_codec.sv
dv/tb.sv
